// File: rtl/modexp_pkg.sv
// shared types for the modular exponentiation block
// no dependencies; imported by modexp_mulmod and modular_exponentiation
package modexp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_NEXT,
      ST_FINISH
   } modexp_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } modexp_mul_status_type;

endpackage

// File: rtl/modular_exponentiation.sv
// modular exponentiation top level: exponent scan sequencer and output register
// depends on modexp_pkg and modexp_mulmod
//
// usage: write the modulus on csr_write_enable/csr_write_data while idle
// (reset value 1). a request word carries base and exponent; one response
// word carries base^exponent mod modulus (1 for a zero exponent).
// one word is worked on at a time; req_stall is high from acceptance until
// the result has been moved into the output register.
// sequence after acceptance: the scan skips the leading zero exponent bits,
// then each remaining bit takes a square and each set bit also a multiply,
// and the result is then loaded into the output register; a zero exponent
// goes straight from the scan to the load. the worst case is set by the
// bit-serial multiplier, which retires one multiplier bit per cycle.
// the next request is accepted only once the result is loaded, so one word
// is finished before the next one is started.
// reset clears the sequencer, the output valid and sets the modulus to 1.
// a stalled response holds in the output register; the next request is still
// accepted and its result waits until that register is free.
module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_base_value,
   input  logic [WIDTH-1:0] req_exponent,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_residue,
   input  logic             csr_write_enable,
   input  logic [WIDTH-1:0] csr_write_data
);
   import modexp_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   modexp_state_type      state_ff, state_in;
   logic [WIDTH-1:0]      modulus_ff, modulus_in;
   logic [WIDTH-1:0]      base_ff, base_in;
   logic [WIDTH-1:0]      exp_ff, exp_in;
   logic [WIDTH-1:0]      acc_ff, acc_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]      rsp_residue_ff, rsp_residue_in;

   logic                  accept;
   logic                  out_free;
   logic                  mul_start;
   logic [WIDTH-1:0]      mul_y;
   modexp_mul_status_type mul_status;
   logic [WIDTH-1:0]      mul_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   modexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x_value (acc_ff),
      .y_value (mul_y),
      .modulus (modulus_ff),
      .status  (mul_status),
      .result  (mul_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[WIDTH-1]) begin
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START:  state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (mul_status.done) state_in = exp_ff[WIDTH-1] ? ST_MUL_START : ST_NEXT;
         end
         ST_MUL_START: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_status.done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = (cnt_ff == CW'(1)) ? ST_FINISH : ST_SQ_START;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      modulus_in     = csr_write_enable ? csr_write_data : modulus_ff;
      base_in        = base_ff;
      exp_in         = exp_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_residue_in = rsp_residue_ff;
      mul_start      = 1'b0;
      mul_y          = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in = req_base_value;
               exp_in  = req_exponent;
               acc_in  = WIDTH'(1);
               cnt_in  = CW'(WIDTH);
            end
         end
         ST_SCAN: begin
            // skip leading zeros of the exponent
            if (cnt_ff != '0 && !exp_ff[WIDTH-1]) begin
               exp_in = {exp_ff[WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_SQ_START: begin
            mul_start = 1'b1;
         end
         ST_SQ_WAIT, ST_MUL_WAIT: begin
            if (mul_status.done) acc_in = mul_result;
         end
         ST_MUL_START: begin
            mul_start = 1'b1;
            mul_y     = base_ff;
         end
         ST_NEXT: begin
            exp_in = {exp_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_residue_in = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      base_ff        <= base_in;
      exp_ff         <= exp_in;
      acc_ff         <= acc_in;
      rsp_residue_ff <= rsp_residue_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> (state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT))
      else $error("multiplier finished outside a wait state");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_status.busy)
      else $error("multiplier started while busy");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN && acc_ff == WIDTH'(1)))
      else $error("accepted word did not start a scan");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && modulus_ff != '0) |-> (acc_ff < modulus_ff))
      else $error("running value not reduced");

endmodule

// File: rtl/modexp_mulmod.sv
// bit-serial modular multiplier: r = 2r + y_bit * x, reduced each cycle
// depends on modexp_pkg for the status struct
module modexp_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [WIDTH-1:0]                  x_value,
   input  logic [WIDTH-1:0]                  y_value,
   input  logic [WIDTH-1:0]                  modulus,
   output modexp_pkg::modexp_mul_status_type status,
   output logic [WIDTH-1:0]                  result
);
   import modexp_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] xr_ff, xr_in;
   logic [WIDTH-1:0] r_ff, r_in;

   logic [WIDTH+1:0] sum, m1, m2, diff1, diff2;
   logic [WIDTH-1:0] step;

   // sum < 3m, so one of three candidates is in range
   always_comb begin
      m1    = {2'b00, modulus};
      m2    = {1'b0, modulus, 1'b0};
      sum   = {1'b0, r_ff, 1'b0} + (y_ff[WIDTH-1] ? {2'b00, xr_ff} : '0);
      diff1 = sum - m1;
      diff2 = sum - m2;
      if (modulus == '0) begin
         step = sum[WIDTH-1:0];
      end else if (sum >= m2) begin
         step = diff2[WIDTH-1:0];
      end else if (sum >= m1) begin
         step = diff1[WIDTH-1:0];
      end else begin
         step = sum[WIDTH-1:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      y_in    = y_ff;
      xr_in   = xr_ff;
      r_in    = r_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(WIDTH);
         y_in   = y_value;
         // the x operand is already below the modulus except the initial 1 with modulus 1
         xr_in  = (modulus == WIDTH'(1)) ? '0 : x_value;
         r_in   = '0;
      end else if (run_ff) begin
         r_in   = step;
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      y_ff  <= y_in;
      xr_ff <= xr_in;
      r_ff  <= r_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

endmodule
